>>> hw/rtl/mbfr_pkg.sv
// ----------------------------------------------------------------------------
// Meter bus frame receiver package
// Shared constants, register map, status codes and parser state encoding.
// ----------------------------------------------------------------------------
package mbfr_pkg;

   // Address field length of a frame, in bytes
   localparam int ADDRESS_BYTES = 7;

   // Default width of the tick counter
   localparam int TICK_BITS_DEFAULT = 32;

   // Register reset values
   localparam logic [31:0] TIMEOUT_RESET    = 32'd100;
   localparam logic [7:0]  START_CODE_RESET = 8'h68;
   localparam logic [7:0]  TYPE_CODE_RESET  = 8'h20;
   localparam logic [7:0]  END_CODE_RESET   = 8'h16;

   // Register map, word index into the configuration space
   typedef enum logic [1:0] {
      REG_TIMEOUT    = 2'd0,
      REG_START_CODE = 2'd1,
      REG_TYPE_CODE  = 2'd2,
      REG_END_CODE   = 2'd3
   } csr_index_type;

   // Frame verdict reported on the end byte
   typedef enum logic [1:0] {
      STATUS_NONE    = 2'd0,
      STATUS_GOOD    = 2'd1,
      STATUS_BAD_SUM = 2'd2,
      STATUS_BAD_END = 2'd3
   } frame_status_type;

   // Parser state, one-hot
   typedef enum logic [7:0] {
      ST_HUNT  = 8'b0000_0001,
      ST_TYPE  = 8'b0000_0010,
      ST_ADDR  = 8'b0000_0100,
      ST_CTRL  = 8'b0000_1000,
      ST_LEN   = 8'b0001_0000,
      ST_DATA  = 8'b0010_0000,
      ST_CHECK = 8'b0100_0000,
      ST_END   = 8'b1000_0000
   } parse_state_type;

endpackage

>>> hw/rtl/meter_bus_frame_receiver.sv
// ----------------------------------------------------------------------------
// Meter bus frame receiver
// Parses received bytes into frames (start, type, address, control, length,
// data, checksum, end), reports every kept byte with its index and judges
// each frame at its end byte. Partial frames are dropped after a tick gap.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   rx_byte, now_tick
//   rsp_      out        rsp_valid/rsp_stall   frame_byte .. data_length
//   csr_      in/out     APB, pready tied high timeout, start/type/end codes
//
// One transaction per cycle sustained while the result side does not stall;
// a request passes from the input register through the parser into the result
// register. The parser state loop closes around the parser state registers.
// reset is synchronous, active high; it clears control state and the CSRs.
// A stalled result holds; the input register still takes one more transaction
// and req_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module meter_bus_frame_receiver
   import mbfr_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_now_tick,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic [8:0]  rsp_byte_index,
   output logic        rsp_byte_kept,
   output logic        rsp_frame_done,
   output logic [1:0]  rsp_frame_status,
   output logic [7:0]  rsp_control_code,
   output logic [7:0]  rsp_data_length,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [31:0] timeout_ff;
   logic [7:0]  start_code_ff;
   logic [7:0]  type_code_ff;
   logic [7:0]  end_code_ff;
   logic        csr_write;
   csr_index_type csr_index;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_tick_ff;

   // Parser state
   parse_state_type      state_ff, state_in;
   logic [8:0]           windex_ff, windex_in;
   logic [7:0]           remain_ff, remain_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           check_ff, check_in;
   logic [TICK_BITS-1:0] last_tick_ff, last_tick_in;
   logic [7:0]           ctrl_ff, ctrl_in;
   logic [7:0]           len_ff, len_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [8:0]  out_index_ff;
   logic        out_kept_ff;
   logic        out_done_ff;
   frame_status_type out_status_ff;

   // Handshake
   logic req_accept;
   logic out_load;
   logic proc;

   // Parser working signals
   logic [63:0]          now_wide;
   logic [TICK_BITS-1:0] now_t;
   logic [TICK_BITS-1:0] gap;
   logic                 timed_out;
   parse_state_type      st;
   logic [8:0]           wi;
   logic [7:0]           sum_base;
   logic                 kept;
   logic                 done;
   logic [8:0]           idx;
   logic [7:0]           remain_dec;
   frame_status_type     status;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         start_code_ff <= START_CODE_RESET;
         type_code_ff  <= TYPE_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_TIMEOUT:    timeout_ff    <= csr_pwdata;
            REG_START_CODE: start_code_ff <= csr_pwdata[7:0];
            REG_TYPE_CODE:  type_code_ff  <= csr_pwdata[7:0];
            REG_END_CODE:   end_code_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TIMEOUT:    csr_prdata = timeout_ff;
         REG_START_CODE: csr_prdata = {24'd0, start_code_ff};
         REG_TYPE_CODE:  csr_prdata = {24'd0, type_code_ff};
         REG_END_CODE:   csr_prdata = {24'd0, end_code_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake: input register feeds the parser when the result register
   // is empty or being emptied
   // ------------------------------------------------------------------
   assign out_load   = !out_valid_ff || !rsp_stall;
   assign proc       = in_valid_ff && out_load;
   assign req_stall  = in_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   // ------------------------------------------------------------------
   // Parser, one byte per pass
   // ------------------------------------------------------------------
   always_comb begin
      now_wide   = {32'd0, in_tick_ff};
      now_t      = now_wide[TICK_BITS-1:0];
      gap        = now_t - last_tick_ff;
      timed_out  = 64'(gap) > 64'(timeout_ff);
      remain_dec = remain_ff - 8'd1;

      // drop a partial frame after a long gap
      st = timed_out ? ST_HUNT : state_ff;
      wi = timed_out ? 9'd0 : windex_ff;

      state_in     = st;
      sum_base     = sum_ff;
      remain_in    = remain_ff;
      check_in     = check_ff;
      ctrl_in      = ctrl_ff;
      len_in       = len_ff;
      kept         = 1'b0;
      done         = 1'b0;
      status       = STATUS_NONE;

      case (st)
         ST_HUNT: begin
            if (in_byte_ff == start_code_ff) begin
               kept      = 1'b1;
               wi        = 9'd0;
               sum_base  = 8'd0;
               ctrl_in   = 8'd0;
               len_in    = 8'd0;
               remain_in = 8'd0;
               state_in  = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (in_byte_ff == type_code_ff) begin
               kept     = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            kept = 1'b1;
            if ((10'(wi) + 10'd1) >= 10'(ADDRESS_BYTES + 2)) begin
               state_in = ST_CTRL;
            end
         end
         ST_CTRL: begin
            kept     = 1'b1;
            ctrl_in  = in_byte_ff;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            kept      = 1'b1;
            len_in    = in_byte_ff;
            remain_in = in_byte_ff;
            state_in  = (in_byte_ff != 8'd0) ? ST_DATA : ST_CHECK;
         end
         ST_DATA: begin
            kept      = 1'b1;
            remain_in = remain_dec;
            if (remain_dec == 8'd0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            kept     = 1'b1;
            check_in = in_byte_ff;
            state_in = ST_END;
         end
         ST_END: begin
            kept = 1'b1;
            done = 1'b1;
            if (in_byte_ff != end_code_ff) begin
               status = STATUS_BAD_END;
            end else if (sum_ff != check_ff) begin
               status = STATUS_BAD_SUM;
            end else begin
               status = STATUS_GOOD;
            end
            state_in = ST_HUNT;
         end
         default: begin
            state_in = ST_HUNT;
            wi       = 9'd0;
         end
      endcase

      sum_in       = sum_base;
      windex_in    = wi;
      last_tick_in = last_tick_ff;
      idx          = 9'd0;
      if (kept) begin
         idx = wi;
         // the checksum and end bytes are not summed
         if (state_in != ST_END && !done) begin
            sum_in = sum_base + in_byte_ff;
         end
         windex_in    = done ? 9'd0 : wi + 9'd1;
         last_tick_in = now_t;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_HUNT;
         windex_ff    <= 9'd0;
         remain_ff    <= 8'd0;
         sum_ff       <= 8'd0;
         check_ff     <= 8'd0;
         last_tick_ff <= '0;
         ctrl_ff      <= 8'd0;
         len_ff       <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (proc) begin
            state_ff     <= state_in;
            windex_ff    <= windex_in;
            remain_ff    <= remain_in;
            sum_ff       <= sum_in;
            check_ff     <= check_in;
            last_tick_ff <= last_tick_in;
            ctrl_ff      <= ctrl_in;
            len_ff       <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
         in_tick_ff <= req_now_tick;
      end
      if (proc) begin
         out_byte_ff   <= in_byte_ff;
         out_index_ff  <= idx;
         out_kept_ff   <= kept;
         out_done_ff   <= done;
         out_status_ff <= status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_byte   = out_byte_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_byte_kept    = out_kept_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_control_code = ctrl_ff;
   assign rsp_data_length  = len_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_done_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_byte_kept)
      else $error("frame end reported on a dropped byte");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done == (rsp_frame_status != STATUS_NONE)))
      else $error("frame status disagrees with frame end");

   a_drop_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_kept |-> rsp_byte_index == 9'd0)
      else $error("dropped byte carries a non-zero index");

   a_end_hunt: assert property (@(posedge clock) disable iff (reset)
      proc && done |=> state_ff == ST_HUNT && windex_ff == 9'd0)
      else $error("parser did not return to hunting after a frame end");

endmodule

>>> tb/sv/tb_meter_bus_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Meter bus frame receiver testbench
// Drives received bytes with tick stamps through a directed table and then
// random frames (good, bad checksum, bad end, wrong type, timed out), under
// several register settings and idle patterns. Every byte report is checked
// field by field against its typed row or a behavioural parser in step.
// ----------------------------------------------------------------------------
module tb_meter_bus_frame_receiver;
   import mbfr_pkg::*;

   typedef struct packed {
      logic [7:0]       frame_byte;
      logic [8:0]       byte_index;
      logic             byte_kept;
      logic             frame_done;
      frame_status_type frame_status;
      logic [7:0]       control_code;
      logic [7:0]       data_length;
   } byte_report_type;

   typedef struct {
      logic [7:0]      rx_byte;
      logic [31:0]     now_tick;
      bit              typed;
      byte_report_type report;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [31:0] req_now_tick = 32'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic [8:0]  rsp_byte_index;
   logic        rsp_byte_kept;
   logic        rsp_frame_done;
   logic [1:0]  rsp_frame_status;
   logic [7:0]  rsp_control_code;
   logic [7:0]  rsp_data_length;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   meter_bus_frame_receiver u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copies
   logic [31:0] cfg_timeout;
   logic [7:0]  cfg_start;
   logic [7:0]  cfg_type;
   logic [7:0]  cfg_end;

   // parser copy
   parse_state_type parser_state;
   logic [8:0]      parser_index;
   logic [7:0]      parser_left;
   logic [7:0]      parser_sum;
   logic [7:0]      parser_check;
   logic [31:0]     parser_last_tick;
   logic [7:0]      parser_control;
   logic [7:0]      parser_length;

   byte_report_type byte_reports_due[$];
   table_row_type   directed_rows[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           frames_made = 0;
   int unsigned  req_gap_pct = 0;
   int unsigned  rsp_hold_pct = 0;
   int           hold_left = 0;
   int           results_seen = 0;
   logic [31:0]  tick_now = 32'h0;

   function automatic byte_report_type parse_rx_byte(input logic [7:0] b,
                                                     input logic [31:0] t);
      byte_report_type  r;
      logic [31:0]      gap;
      logic             kept;
      logic             done;
      frame_status_type verdict;
      logic [8:0]       idx;
      kept = 1'b0;
      done = 1'b0;
      verdict = STATUS_NONE;
      idx = 9'd0;
      gap = t - parser_last_tick;
      if (gap > cfg_timeout) begin
         parser_state = ST_HUNT;
         parser_index = 9'd0;
      end
      case (parser_state)
         ST_HUNT: begin
            if (b == cfg_start) begin
               kept = 1'b1;
               parser_index = 9'd0;
               parser_sum = 8'd0;
               parser_control = 8'd0;
               parser_length = 8'd0;
               parser_left = 8'd0;
               parser_state = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (b == cfg_type) begin
               kept = 1'b1;
               parser_state = ST_ADDR;
            end
         end
         ST_ADDR: begin
            kept = 1'b1;
            if (parser_index + 9'd1 >= 9'(2 + ADDRESS_BYTES)) parser_state = ST_CTRL;
         end
         ST_CTRL: begin
            kept = 1'b1;
            parser_control = b;
            parser_state = ST_LEN;
         end
         ST_LEN: begin
            kept = 1'b1;
            parser_length = b;
            parser_left = b;
            if (b != 8'd0) parser_state = ST_DATA;
            else parser_state = ST_CHECK;
         end
         ST_DATA: begin
            kept = 1'b1;
            parser_left = parser_left - 8'd1;
            if (parser_left == 8'd0) parser_state = ST_CHECK;
         end
         ST_CHECK: begin
            kept = 1'b1;
            parser_check = b;
            parser_state = ST_END;
         end
         ST_END: begin
            kept = 1'b1;
            done = 1'b1;
            if (b != cfg_end) verdict = STATUS_BAD_END;
            else if (parser_sum != parser_check) verdict = STATUS_BAD_SUM;
            else verdict = STATUS_GOOD;
            parser_state = ST_HUNT;
         end
         default: begin
            parser_state = ST_HUNT;
            parser_index = 9'd0;
         end
      endcase
      if (kept) begin
         idx = parser_index;
         // the checksum byte and the end byte stay out of the sum
         if (parser_state != ST_END && !done) parser_sum = parser_sum + b;
         parser_index = done ? 9'd0 : parser_index + 9'd1;
         parser_last_tick = t;
      end
      r.frame_byte = b;
      r.byte_index = idx;
      r.byte_kept = kept;
      r.frame_done = done;
      r.frame_status = verdict;
      r.control_code = parser_control;
      r.data_length = parser_length;
      return r;
   endfunction

   function automatic byte_report_type report(input logic [7:0] b, input logic [8:0] idx,
                                              input logic kept, input logic done,
                                              input frame_status_type verdict,
                                              input logic [7:0] ctrl, input logic [7:0] len);
      byte_report_type r;
      r.frame_byte = b;
      r.byte_index = idx;
      r.byte_kept = kept;
      r.frame_done = done;
      r.frame_status = verdict;
      r.control_code = ctrl;
      r.data_length = len;
      return r;
   endfunction

   function automatic logic [31:0] next_tick();
      logic [31:0] adv;
      if (cfg_timeout != 32'hFFFF_FFFF && $urandom_range(0, 99) < 2)
         adv = cfg_timeout + 32'd1 + $urandom_range(0, 40);
      else
         adv = $urandom_range(0, (cfg_timeout < 32'd200) ? cfg_timeout : 32'd200);
      tick_now = tick_now + adv;
      return tick_now;
   endfunction

   task automatic add_row(input logic [7:0] b, input logic [31:0] t, input bit typed,
                          input byte_report_type r);
      table_row_type row;
      row.rx_byte = b;
      row.now_tick = t;
      row.typed = typed;
      row.report = r;
      directed_rows.push_back(row);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic [31:0] t, input bit typed,
                            input byte_report_type typed_report);
      byte_report_type r;
      r = parse_rx_byte(b, t);
      if (typed) r = typed_report;
      byte_reports_due.push_back(r);
      items_sent++;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_now_tick <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame();
      logic [7:0] sum;
      logic [7:0] len;
      logic [7:0] b;
      int         noise;
      noise = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
      repeat (noise) send_byte(8'($urandom_range(0, 255)), next_tick(), 1'b0, '0);
      send_byte(cfg_start, next_tick(), 1'b0, '0);
      sum = cfg_start;
      if ($urandom_range(0, 99) < 10)
         send_byte(cfg_type ^ 8'($urandom_range(1, 255)), next_tick(), 1'b0, '0);
      send_byte(cfg_type, next_tick(), 1'b0, '0);
      sum = sum + cfg_type;
      // address bytes and control byte
      repeat (ADDRESS_BYTES + 1) begin
         b = 8'($urandom_range(0, 255));
         send_byte(b, next_tick(), 1'b0, '0);
         sum = sum + b;
      end
      frames_made++;
      if (frames_made % 40 == 20) len = 8'd255;
      else if ($urandom_range(0, 99) < 75) len = 8'($urandom_range(0, 6));
      else if ($urandom_range(0, 99) < 90) len = 8'($urandom_range(7, 40));
      else len = 8'($urandom_range(41, 255));
      send_byte(len, next_tick(), 1'b0, '0);
      sum = sum + len;
      repeat (len) begin
         b = 8'($urandom_range(0, 255));
         send_byte(b, next_tick(), 1'b0, '0);
         sum = sum + b;
      end
      b = sum;
      if ($urandom_range(0, 99) < 15) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, next_tick(), 1'b0, '0);
      b = cfg_end;
      if ($urandom_range(0, 99) < 10) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, next_tick(), 1'b0, '0);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (which)
         REG_TIMEOUT:    cfg_timeout = value;
         REG_START_CODE: cfg_start = value[7:0];
         REG_TYPE_CODE:  cfg_type = value[7:0];
         REG_END_CODE:   cfg_end = value[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (byte_reports_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (mismatches < 40)
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side: check each transaction and drive the stall pattern
   always @(posedge clock) begin : result_side
      byte_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (byte_reports_due.size() == 0) begin
            if (mismatches < 40)
               $display("%0t unexpected result: expected none, actual byte %0h",
                        $time, rsp_frame_byte);
            mismatches++;
         end else begin
            want = byte_reports_due.pop_front();
            check_field("frame_byte", want.frame_byte, rsp_frame_byte);
            check_field("byte_index", want.byte_index, rsp_byte_index);
            check_field("byte_kept", want.byte_kept, rsp_byte_kept);
            check_field("frame_done", want.frame_done, rsp_frame_done);
            check_field("frame_status", want.frame_status, rsp_frame_status);
            check_field("control_code", want.control_code, rsp_control_code);
            check_field("data_length", want.data_length, rsp_data_length);
         end
         results_seen++;
         // hold off long enough to back the input up
         if (results_seen % 600 == 300) hold_left = 60;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
      end
   end

   initial begin : stimulus
      int target;
      cfg_timeout = TIMEOUT_RESET;
      cfg_start = START_CODE_RESET;
      cfg_type = TYPE_CODE_RESET;
      cfg_end = END_CODE_RESET;
      parser_state = ST_HUNT;
      parser_index = 9'd0;
      parser_left = 8'd0;
      parser_sum = 8'd0;
      parser_check = 8'd0;
      parser_last_tick = 32'd0;
      parser_control = 8'd0;
      parser_length = 8'd0;

      // stray byte, start, wrong type, type, address, zero length, bad end
      add_row(8'h00, 32'd0, 1'b1, report(8'h00, 9'd0, 1'b0, 1'b0, STATUS_NONE, 8'h00, 8'h00));
      add_row(8'h68, 32'd1, 1'b1, report(8'h68, 9'd0, 1'b1, 1'b0, STATUS_NONE, 8'h00, 8'h00));
      add_row(8'h55, 32'd2, 1'b1, report(8'h55, 9'd0, 1'b0, 1'b0, STATUS_NONE, 8'h00, 8'h00));
      add_row(8'h20, 32'd3, 1'b1, report(8'h20, 9'd1, 1'b1, 1'b0, STATUS_NONE, 8'h00, 8'h00));
      add_row(8'hFF, 32'd4, 1'b0, '0);
      add_row(8'h00, 32'd5, 1'b0, '0);
      add_row(8'hAA, 32'd6, 1'b0, '0);
      add_row(8'h55, 32'd7, 1'b0, '0);
      add_row(8'h01, 32'd8, 1'b0, '0);
      add_row(8'h80, 32'd9, 1'b0, '0);
      add_row(8'h7F, 32'd10, 1'b0, '0);
      add_row(8'hFF, 32'd11, 1'b0, '0);
      add_row(8'h00, 32'd12, 1'b0, '0);
      add_row(8'hA5, 32'd13, 1'b0, '0);
      add_row(8'h00, 32'd14, 1'b1, report(8'h00, 9'd12, 1'b1, 1'b1, STATUS_BAD_END,
                                          8'hFF, 8'h00));
      // start, then a gap one tick past the timeout, then a wrapping tick
      add_row(8'h68, 32'd15, 1'b0, '0);
      add_row(8'h20, 32'd116, 1'b1, report(8'h20, 9'd0, 1'b0, 1'b0, STATUS_NONE,
                                           8'h00, 8'h00));
      add_row(8'h68, 32'hFFFF_FFF0, 1'b1, report(8'h68, 9'd0, 1'b1, 1'b0, STATUS_NONE,
                                                 8'h00, 8'h00));
      add_row(8'h20, 32'h0000_0010, 1'b1, report(8'h20, 9'd1, 1'b1, 1'b0, STATUS_NONE,
                                                 8'h00, 8'h00));

      req_gap_pct = 35;
      rsp_hold_pct = 47;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].now_tick,
                   directed_rows[i].typed, directed_rows[i].report);
      tick_now = 32'h0000_0010;

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            req_gap_pct = 47;
            rsp_hold_pct = 35;
         end else if (phase == 4) begin
            req_gap_pct = 0;
            rsp_hold_pct = 0;
         end
         if (phase != 0) drain();
         case (phase)
            1: begin
               write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
               write_reg(REG_START_CODE, 32'h00);
               write_reg(REG_TYPE_CODE, 32'hFF);
               write_reg(REG_END_CODE, 32'h00);
               tick_now = 32'hFFFF_FF00;
            end
            2: begin
               write_reg(REG_TIMEOUT, 32'd0);
               write_reg(REG_START_CODE, 32'hFF);
               write_reg(REG_TYPE_CODE, 32'h00);
               write_reg(REG_END_CODE, 32'hFF);
            end
            3: begin
               write_reg(REG_TIMEOUT, 32'd37);
               write_reg(REG_START_CODE, 32'h7E);
               write_reg(REG_TYPE_CODE, 32'h81);
               write_reg(REG_END_CODE, 32'h0A);
            end
            4: begin
               write_reg(REG_TIMEOUT, 32'd1);
               write_reg(REG_START_CODE, $urandom_range(0, 255));
               write_reg(REG_TYPE_CODE, $urandom_range(0, 255));
               write_reg(REG_END_CODE, $urandom_range(0, 255));
            end
            5: begin
               write_reg(REG_TIMEOUT, TIMEOUT_RESET);
               write_reg(REG_START_CODE, 32'(START_CODE_RESET));
               write_reg(REG_TYPE_CODE, 32'(TYPE_CODE_RESET));
               write_reg(REG_END_CODE, 32'(END_CODE_RESET));
               tick_now = 32'hFFFF_F800;
            end
            default: ;
         endcase
         target = items_sent + 280;
         while (items_sent < target) send_frame();
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && byte_reports_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mbfr_pkg.sv
hw/rtl/meter_bus_frame_receiver.sv
tb/sv/tb_meter_bus_frame_receiver.sv
